// File: rtl/core/dpir_pkg.sv
// ----------------------------------------------------------------------------
// DNS intercept package
// Shared widths, protocol constants, verdict codes and the records that pass
// between the front end, the decision queue and the reply generator.
// ----------------------------------------------------------------------------
`default_nettype none

package dpir_pkg;

   // Packet length counter
   localparam int unsigned MAX_PACKET_BYTES = 65535;
   localparam int unsigned COUNT_W          = $clog2(MAX_PACKET_BYTES + 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_PACKET_BYTES);

   // Configuration port
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERCEPT_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DNS_SERVER_IP    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIDGE_ACTIVE    = 2'd2;

   // Protocol numbers and header limits
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [15:0] DNS_PORT       = 16'd53;
   localparam logic [3:0]  IP_VERSION     = 4'd4;
   localparam logic [16:0] MIN_PKT_LEN    = 17'd28;
   localparam logic [16:0] IP_HDR_MIN     = 17'd20;
   localparam logic [16:0] UDP_HDR_LEN    = 17'd8;
   localparam logic [16:0] TCP_HDR_MIN    = 17'd20;
   localparam int unsigned TCP_SYN_BIT    = 1;

   // Reset reply layout
   localparam int unsigned RST_LEN          = 40;
   localparam int unsigned RST_IDX_W        = $clog2(RST_LEN);
   localparam logic [RST_IDX_W-1:0] RST_LAST_IDX = RST_IDX_W'(RST_LEN - 1);
   localparam logic [7:0]  IP_VER_IHL       = 8'h45;
   localparam logic [7:0]  IP_FLAG_DF       = 8'h40;
   localparam logic [7:0]  IP_TTL           = 8'd64;
   localparam logic [7:0]  RST_TOTAL_LEN    = 8'(RST_LEN);
   localparam logic [7:0]  TCP_OFF_BYTE     = 8'h50;
   localparam logic [7:0]  TCP_FLAGS_RSTACK = 8'h14;
   localparam logic [15:0] RST_TCP_LEN      = 16'd20;

   // Constant words of the two checksums (header words that never change)
   localparam logic [15:0] IP_CK_BASE  = {IP_VER_IHL, 8'h00} + {8'h00, RST_TOTAL_LEN}
                                       + {IP_FLAG_DF, 8'h00} + {IP_TTL, PROTO_TCP};
   localparam logic [15:0] TCP_CK_BASE = {8'h00, PROTO_TCP} + RST_TCP_LEN + DNS_PORT
                                       + {TCP_OFF_BYTE, TCP_FLAGS_RSTACK};

   // Decision queue
   localparam int unsigned QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      VERDICT_PASS        = 3'd0,
      VERDICT_UDP_DIVERT  = 3'd1,
      VERDICT_TCP_RESET   = 3'd2,
      VERDICT_TCP_DROP    = 3'd3,
      VERDICT_BRIDGE_DROP = 3'd4
   } verdict_type;

   typedef struct packed {
      logic                  intercept_enable;
      logic [31:0]           dns_server_ip;
      logic                  bridge_active;
   } cfg_type;

   // Header fields gathered while a packet streams in
   typedef struct packed {
      logic [COUNT_W-1:0]    byte_count;
      logic [7:0]            ver_ihl;
      logic [15:0]           total_length;
      logic [7:0]            protocol;
      logic [31:0]           source_ip;
      logic [31:0]           dest_ip;
      logic [15:0]           source_port;
      logic [15:0]           dest_port;
      logic [31:0]           seq_or_udp_len;
      logic [3:0]            tcp_offset;
      logic [7:0]            tcp_flags;
   } pkt_fields_type;

   // One decision handed from the front end to the reply generator
   typedef struct packed {
      verdict_type           verdict;
      logic [31:0]           source_ip;
      logic [31:0]           dest_ip;
      logic [15:0]           source_port;
      logic [31:0]           ack_num;
      logic [19:0]           ip_sum;
      logic [19:0]           tcp_sum;
   } reply_job_type;

endpackage

`default_nettype wire

// File: rtl/core/dpir_req_if.sv
// ----------------------------------------------------------------------------
// Packet byte channel
// Valid/ready channel carrying one IPv4 packet byte and its last-byte mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpir_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pkt_byte;
   logic       last_byte;

   modport source (output valid, output pkt_byte, output last_byte, input ready);
   modport sink   (input valid, input pkt_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/core/dpir_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying a verdict item or one byte of a reset reply.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpir_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] verdict;
   logic [7:0] reply_byte;
   logic       reply_valid;
   logic       last_result;

   modport source (output valid, output verdict, output reply_byte, output reply_valid,
                   output last_result, input ready);
   modport sink   (input valid, input verdict, input reply_byte, input reply_valid,
                   input last_result, output ready);
endinterface

`default_nettype wire

// File: rtl/core/dpir_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpir_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/dpir_front.sv
// ----------------------------------------------------------------------------
// DNS intercept front end
// Captures header fields byte by byte, classifies the packet at its last
// byte and hands a decision record, with partial checksums, to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dpir_front (
   input  logic                    clock,
   input  logic                    reset,
   input  dpir_pkg::cfg_type       cfg,
   dpir_req_if.sink                req_ch,
   output logic                    push_valid,
   input  logic                    push_ready,
   output dpir_pkg::reply_job_type push_job
);
   import dpir_pkg::*;

   pkt_fields_type     pkt_ff, pkt_in;
   pkt_fields_type     cap;
   pkt_fields_type     s1_pkt_ff, s1_pkt_in;
   logic               s1_valid_ff, s1_valid_in;
   logic               s2_valid_ff, s2_valid_in;
   verdict_type        s2_verdict_ff, s2_verdict_in;
   logic [31:0]        s2_src_ip_ff, s2_src_ip_in;
   logic [31:0]        s2_dst_ip_ff, s2_dst_ip_in;
   logic [15:0]        s2_sport_ff, s2_sport_in;
   logic [31:0]        s2_ack_ff, s2_ack_in;
   logic [16:0]        s2_src_sum_ff, s2_src_sum_in;
   logic [16:0]        s2_dst_sum_ff, s2_dst_sum_in;

   logic               accept;
   logic               s1_en;
   logic               s2_en;
   logic [7:0]         vi;
   logic [5:0]         hlen;
   logic [COUNT_W-1:0] hlen_c;
   logic [COUNT_W-1:0] rel;
   logic [COUNT_W-1:0] pos;

   logic [16:0]        len17, tl17, h17, ulen17, thl17;
   logic               ip_ok, udp_ok, tcp_ok;

   // Stall the stages only when the queue refuses a decision
   assign s2_en        = !s2_valid_ff || push_ready;
   assign s1_en        = !s1_valid_ff || s2_en;
   assign req_ch.ready = s1_en;
   assign accept       = req_ch.valid && s1_en;

   // Capture header and transport fields of the incoming byte
   assign pos    = pkt_ff.byte_count;
   assign vi     = (pos == '0) ? req_ch.pkt_byte : pkt_ff.ver_ihl;
   assign hlen   = {vi[3:0], 2'b00};
   assign hlen_c = COUNT_W'(hlen);
   assign rel    = pos - hlen_c;

   always_comb begin
      cap = pkt_ff;
      if (pos != COUNT_MAX) begin
         cap.byte_count = pos + 1'b1;
         cap.ver_ihl    = vi;
         if (pos == COUNT_W'(2) || pos == COUNT_W'(3)) begin
            cap.total_length = {pkt_ff.total_length[7:0], req_ch.pkt_byte};
         end
         if (pos == COUNT_W'(9)) begin
            cap.protocol = req_ch.pkt_byte;
         end
         if (pos >= COUNT_W'(12) && pos <= COUNT_W'(15)) begin
            cap.source_ip = {pkt_ff.source_ip[23:0], req_ch.pkt_byte};
         end
         if (pos >= COUNT_W'(16) && pos <= COUNT_W'(19)) begin
            cap.dest_ip = {pkt_ff.dest_ip[23:0], req_ch.pkt_byte};
         end
         if (pos >= hlen_c) begin
            if (rel <= COUNT_W'(1)) begin
               cap.source_port = {pkt_ff.source_port[7:0], req_ch.pkt_byte};
            end else if (rel <= COUNT_W'(3)) begin
               cap.dest_port = {pkt_ff.dest_port[7:0], req_ch.pkt_byte};
            end else if (rel <= COUNT_W'(7)) begin
               cap.seq_or_udp_len = {pkt_ff.seq_or_udp_len[23:0], req_ch.pkt_byte};
            end else if (rel == COUNT_W'(12)) begin
               cap.tcp_offset = req_ch.pkt_byte[7:4];
            end else if (rel == COUNT_W'(13)) begin
               cap.tcp_flags = req_ch.pkt_byte;
            end
         end
      end
   end

   // Advance the capture state; clear it once the last byte is taken
   always_comb begin
      pkt_in      = pkt_ff;
      s1_valid_in = s1_valid_ff;
      s1_pkt_in   = s1_pkt_ff;
      if (s1_en) begin
         s1_valid_in = accept && req_ch.last_byte;
      end
      if (accept) begin
         if (req_ch.last_byte) begin
            pkt_in    = '0;
            s1_pkt_in = cap;
         end else begin
            pkt_in = cap;
         end
      end
   end

   // Classify the finished packet
   assign len17  = 17'(s1_pkt_ff.byte_count);
   assign tl17   = 17'(s1_pkt_ff.total_length);
   assign h17    = 17'({s1_pkt_ff.ver_ihl[3:0], 2'b00});
   assign ulen17 = 17'(s1_pkt_ff.seq_or_udp_len[31:16]);
   assign thl17  = 17'({s1_pkt_ff.tcp_offset, 2'b00});

   assign ip_ok = cfg.intercept_enable
               && len17 >= MIN_PKT_LEN
               && s1_pkt_ff.ver_ihl[7:4] == IP_VERSION
               && h17 >= IP_HDR_MIN
               && len17 >= h17 + UDP_HDR_LEN
               && tl17 >= h17 + UDP_HDR_LEN
               && tl17 <= len17
               && s1_pkt_ff.dest_ip == cfg.dns_server_ip;

   assign udp_ok = s1_pkt_ff.protocol == PROTO_UDP
                && ulen17 >= UDP_HDR_LEN
                && h17 + ulen17 <= tl17
                && s1_pkt_ff.dest_port == DNS_PORT;

   assign tcp_ok = s1_pkt_ff.protocol == PROTO_TCP
                && tl17 >= h17 + TCP_HDR_MIN
                && thl17 >= TCP_HDR_MIN
                && thl17 + h17 <= tl17
                && s1_pkt_ff.dest_port == DNS_PORT;

   always_comb begin
      s2_valid_in   = s2_valid_ff;
      s2_verdict_in = s2_verdict_ff;
      s2_src_ip_in  = s2_src_ip_ff;
      s2_dst_ip_in  = s2_dst_ip_ff;
      s2_sport_in   = s2_sport_ff;
      s2_ack_in     = s2_ack_ff;
      s2_src_sum_in = s2_src_sum_ff;
      s2_dst_sum_in = s2_dst_sum_ff;
      if (s2_en) begin
         s2_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            if (!(ip_ok && (udp_ok || tcp_ok))) begin
               s2_verdict_in = VERDICT_PASS;
            end else if (!cfg.bridge_active) begin
               s2_verdict_in = VERDICT_BRIDGE_DROP;
            end else if (udp_ok) begin
               s2_verdict_in = VERDICT_UDP_DIVERT;
            end else if (s1_pkt_ff.tcp_flags[TCP_SYN_BIT]) begin
               s2_verdict_in = VERDICT_TCP_RESET;
            end else begin
               s2_verdict_in = VERDICT_TCP_DROP;
            end
            s2_src_ip_in  = s1_pkt_ff.source_ip;
            s2_dst_ip_in  = s1_pkt_ff.dest_ip;
            s2_sport_in   = s1_pkt_ff.source_port;
            s2_ack_in     = s1_pkt_ff.seq_or_udp_len + 32'd1;
            s2_src_sum_in = 17'(s1_pkt_ff.source_ip[31:16]) + 17'(s1_pkt_ff.source_ip[15:0]);
            s2_dst_sum_in = 17'(s1_pkt_ff.dest_ip[31:16]) + 17'(s1_pkt_ff.dest_ip[15:0]);
         end
      end
   end

   // Finish the raw checksum sums on the way into the queue
   assign push_valid           = s2_valid_ff;
   assign push_job.verdict     = s2_verdict_ff;
   assign push_job.source_ip   = s2_src_ip_ff;
   assign push_job.dest_ip     = s2_dst_ip_ff;
   assign push_job.source_port = s2_sport_ff;
   assign push_job.ack_num     = s2_ack_ff;
   assign push_job.ip_sum      = 20'(s2_src_sum_ff) + 20'(s2_dst_sum_ff) + 20'(IP_CK_BASE);
   assign push_job.tcp_sum     = 20'(s2_src_sum_ff) + 20'(s2_dst_sum_ff)
                               + 20'(TCP_CK_BASE) + 20'(s2_sport_ff)
                               + 20'(s2_ack_ff[31:16]) + 20'(s2_ack_ff[15:0]);

   // Control state and capture fields
   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         pkt_ff      <= pkt_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      s1_pkt_ff     <= s1_pkt_in;
      s2_verdict_ff <= s2_verdict_in;
      s2_src_ip_ff  <= s2_src_ip_in;
      s2_dst_ip_ff  <= s2_dst_ip_in;
      s2_sport_ff   <= s2_sport_in;
      s2_ack_ff     <= s2_ack_in;
      s2_src_sum_ff <= s2_src_sum_in;
      s2_dst_sum_ff <= s2_dst_sum_in;
   end

endmodule

`default_nettype wire

// File: rtl/core/dpir_queue.sv
// ----------------------------------------------------------------------------
// DNS intercept decision queue
// Short first-in first-out store of decision records between the front end
// and the reply generator.
// ----------------------------------------------------------------------------
`default_nettype none

module dpir_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  dpir_pkg::reply_job_type push_job,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output dpir_pkg::reply_job_type pop_job
);
   import dpir_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   reply_job_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed record
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/dpir_back.sv
// ----------------------------------------------------------------------------
// DNS intercept reply generator
// Pops decisions, emits the verdict item and, for a reset verdict, streams
// the 40-byte RST/ACK packet through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dpir_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  dpir_pkg::reply_job_type pop_job,
   dpir_rsp_if.source              rsp_ch
);
   import dpir_pkg::*;

   logic                 active_ff, active_in;
   logic [RST_IDX_W-1:0] idx_ff, idx_in;
   reply_job_type        job_ff, job_in;
   logic [15:0]          ip_ck_ff, ip_ck_in;
   logic [15:0]          tcp_ck_ff, tcp_ck_in;

   logic                 out_valid_ff, out_valid_in;
   verdict_type          out_verdict_ff, out_verdict_in;
   logic [7:0]           out_byte_ff, out_byte_in;
   logic                 out_reply_ff, out_reply_in;
   logic                 out_last_ff, out_last_in;

   logic                 slot_free;
   logic [7:0]           rst_byte;

   // End-around carry fold and complement of a raw ones' complement sum
   function automatic logic [15:0] ck_fold(input logic [19:0] s);
      logic [16:0] f1;
      logic [15:0] f2;
      f1 = 17'(s[15:0]) + 17'(s[19:16]);
      f2 = f1[15:0] + 16'(f1[16]);
      return ~f2;
   endfunction

   assign slot_free = !out_valid_ff || rsp_ch.ready;
   assign pop_ready = slot_free && !active_ff;

   // Select the reset packet byte at the current offset
   always_comb begin
      case (idx_ff)
         6'd0:    rst_byte = IP_VER_IHL;
         6'd3:    rst_byte = RST_TOTAL_LEN;
         6'd6:    rst_byte = IP_FLAG_DF;
         6'd8:    rst_byte = IP_TTL;
         6'd9:    rst_byte = PROTO_TCP;
         6'd10:   rst_byte = ip_ck_ff[15:8];
         6'd11:   rst_byte = ip_ck_ff[7:0];
         6'd12:   rst_byte = job_ff.dest_ip[31:24];
         6'd13:   rst_byte = job_ff.dest_ip[23:16];
         6'd14:   rst_byte = job_ff.dest_ip[15:8];
         6'd15:   rst_byte = job_ff.dest_ip[7:0];
         6'd16:   rst_byte = job_ff.source_ip[31:24];
         6'd17:   rst_byte = job_ff.source_ip[23:16];
         6'd18:   rst_byte = job_ff.source_ip[15:8];
         6'd19:   rst_byte = job_ff.source_ip[7:0];
         6'd21:   rst_byte = DNS_PORT[7:0];
         6'd22:   rst_byte = job_ff.source_port[15:8];
         6'd23:   rst_byte = job_ff.source_port[7:0];
         6'd28:   rst_byte = job_ff.ack_num[31:24];
         6'd29:   rst_byte = job_ff.ack_num[23:16];
         6'd30:   rst_byte = job_ff.ack_num[15:8];
         6'd31:   rst_byte = job_ff.ack_num[7:0];
         6'd32:   rst_byte = TCP_OFF_BYTE;
         6'd33:   rst_byte = TCP_FLAGS_RSTACK;
         6'd36:   rst_byte = tcp_ck_ff[15:8];
         6'd37:   rst_byte = tcp_ck_ff[7:0];
         default: rst_byte = 8'h00;
      endcase
   end

   // Fill the output stage: reply bytes first, else the next decision
   always_comb begin
      active_in      = active_ff;
      idx_in         = idx_ff;
      job_in         = job_ff;
      ip_ck_in       = ip_ck_ff;
      tcp_ck_in      = tcp_ck_ff;
      out_valid_in   = out_valid_ff;
      out_verdict_in = out_verdict_ff;
      out_byte_in    = out_byte_ff;
      out_reply_in   = out_reply_ff;
      out_last_in    = out_last_ff;
      if (slot_free) begin
         if (active_ff) begin
            out_valid_in   = 1'b1;
            out_verdict_in = VERDICT_TCP_RESET;
            out_byte_in    = rst_byte;
            out_reply_in   = 1'b1;
            out_last_in    = idx_ff == RST_LAST_IDX;
            idx_in         = idx_ff + 1'b1;
            active_in      = idx_ff != RST_LAST_IDX;
         end else if (pop_valid) begin
            out_valid_in   = 1'b1;
            out_verdict_in = pop_job.verdict;
            out_byte_in    = 8'h00;
            out_reply_in   = 1'b0;
            out_last_in    = pop_job.verdict != VERDICT_TCP_RESET;
            job_in         = pop_job;
            ip_ck_in       = ck_fold(pop_job.ip_sum);
            tcp_ck_in      = ck_fold(pop_job.tcp_sum);
            active_in      = pop_job.verdict == VERDICT_TCP_RESET;
            idx_in         = '0;
         end else begin
            out_valid_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff         <= job_in;
      ip_ck_ff       <= ip_ck_in;
      tcp_ck_ff      <= tcp_ck_in;
      out_verdict_ff <= out_verdict_in;
      out_byte_ff    <= out_byte_in;
      out_reply_ff   <= out_reply_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.verdict     = out_verdict_ff;
   assign rsp_ch.reply_byte  = out_byte_ff;
   assign rsp_ch.reply_valid = out_reply_ff;
   assign rsp_ch.last_result = out_last_ff;

   // Reply bytes only ever belong to a reset verdict
   a_reply_is_reset: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_reply_ff) |-> (out_verdict_ff == VERDICT_TCP_RESET))
      else $error("reply byte carries a verdict other than TCP reset");

   // A taken reset verdict is followed at once by the first reply byte
   a_reset_starts_reply: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_ch.ready && !out_reply_ff
       && out_verdict_ff == VERDICT_TCP_RESET)
      |=> (out_valid_ff && out_reply_ff && idx_ff == RST_IDX_W'(1)))
      else $error("reset verdict not followed by reply byte zero");

   // More reply bytes are pending while a non-final one is shown
   a_reply_pending: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_reply_ff && !out_last_ff) |-> active_ff)
      else $error("reply stream ended before its last byte");

   // The byte offset stays inside the reset packet
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (idx_ff <= RST_LAST_IDX))
      else $error("reply byte offset out of range");

endmodule

`default_nettype wire

// File: rtl/core/dns_packet_intercept_rst_core.sv
// ----------------------------------------------------------------------------
// DNS intercept with TCP reset
// Top level: configuration registers, front end, decision queue and reply
// generator.
// ----------------------------------------------------------------------------
// The block takes one IPv4 packet byte per cycle on req_ch and never stalls
// a packet byte while the decision queue (4 entries) has room. Each packet
// yields one verdict item on rsp_ch, registered through the front-end
// stages, the queue and the output stage; a TCP SYN to the configured DNS
// server on port 53 with the bridge active adds 40 reply bytes, one per
// cycle while rsp_ch is ready, so the output port is busy through each
// reset reply and the queue absorbs the packets that end meanwhile. Input
// stalls only when the queue is full. Configuration writes on csr_ch are
// always taken; register 0 enables interception, 1 holds the server address,
// 2 marks the bridge active. Writes to any other index are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_packet_intercept_rst_core (
   input  logic       clock,
   input  logic       reset,
   dpir_req_if.sink   req_ch,
   dpir_rsp_if.source rsp_ch,
   dpir_csr_if.sink   csr_ch
);
   import dpir_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   logic          push_valid, push_ready;
   reply_job_type push_job;
   logic          pop_valid, pop_ready;
   reply_job_type pop_job;

   // Take configuration writes
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_INTERCEPT_ENABLE: cfg_in.intercept_enable = csr_ch.data[0];
            CSR_DNS_SERVER_IP:    cfg_in.dns_server_ip    = csr_ch.data;
            CSR_BRIDGE_ACTIVE:    cfg_in.bridge_active    = csr_ch.data[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dpir_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   dpir_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   dpir_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// DNS intercept with TCP reset: block-level testbench
// Streams IPv4 packets byte by byte into the core under several register
// settings. A predictor classifies each packet and builds the
// expected RST/ACK reply, and every result item is checked field by field.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dpir_pkg::*;

   localparam int unsigned RESET_CYCLES = 6;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned CYCLE_LIMIT  = 200_000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [1:0] {MATCH_NONE, MATCH_UDP, MATCH_TCP} match_kind_type;

   typedef struct {
      logic [7:0] value;
      logic       last;
      bit         hold;
   } pkt_byte_type;

   typedef struct {
      verdict_type verdict;
      logic [7:0]  reply_byte;
      logic        reply_valid;
      logic        last_result;
   } rsp_item_type;

   logic clock = 1'b0;
   logic reset;

   dpir_req_if req_ch ();
   dpir_rsp_if rsp_ch ();
   dpir_csr_if csr_ch ();

   dns_packet_intercept_rst_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Shadow registers and the header fields of the packet in flight
   cfg_type        cfg;
   pkt_fields_type hdr;

   pkt_byte_type bytes_to_send [$];
   rsp_item_type rsp_items_due [$];

   bit          calm = 1'b0;
   int unsigned idle_left  = 0;
   int unsigned stall_left = 0;
   int unsigned error_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned packets_queued = 0;
   int unsigned verdicts_seen [5];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Latch the header fields that a byte at this position belongs to
   function automatic void capture_header(int unsigned pos, logic [7:0] b);
      int unsigned h, r;
      if (pos == 0) hdr.ver_ihl = b;
      if (pos == 2 || pos == 3) hdr.total_length = {hdr.total_length[7:0], b};
      if (pos == 9) hdr.protocol = b;
      if (pos >= 12 && pos <= 15) hdr.source_ip = {hdr.source_ip[23:0], b};
      if (pos >= 16 && pos <= 19) hdr.dest_ip = {hdr.dest_ip[23:0], b};
      h = 4 * int'(hdr.ver_ihl[3:0]);
      if (pos < h) return;
      r = pos - h;
      if (r <= 1) hdr.source_port = {hdr.source_port[7:0], b};
      else if (r <= 3) hdr.dest_port = {hdr.dest_port[7:0], b};
      else if (r <= 7) hdr.seq_or_udp_len = {hdr.seq_or_udp_len[23:0], b};
      else if (r == 12) hdr.tcp_offset = b[7:4];
      else if (r == 13) hdr.tcp_flags = b;
   endfunction

   function automatic match_kind_type classify_packet();
      int unsigned h, len, ulen, thl;
      h    = 4 * int'(hdr.ver_ihl[3:0]);
      len  = int'(hdr.byte_count);
      ulen = int'(hdr.seq_or_udp_len[31:16]);
      thl  = 4 * int'(hdr.tcp_offset);
      if (!cfg.intercept_enable || len < 28) return MATCH_NONE;
      if (hdr.ver_ihl[7:4] != IP_VERSION || h < 20 || len < h + 8) return MATCH_NONE;
      if (hdr.total_length < h + 8 || hdr.total_length > len) return MATCH_NONE;
      if (hdr.dest_ip != cfg.dns_server_ip) return MATCH_NONE;
      if (hdr.protocol == PROTO_UDP) begin
         if (ulen < 8 || h + ulen > hdr.total_length) return MATCH_NONE;
         return (hdr.dest_port == DNS_PORT) ? MATCH_UDP : MATCH_NONE;
      end
      if (hdr.protocol == PROTO_TCP) begin
         if (hdr.total_length < h + 20) return MATCH_NONE;
         if (thl < 20 || thl > hdr.total_length - h) return MATCH_NONE;
         return (hdr.dest_port == DNS_PORT) ? MATCH_TCP : MATCH_NONE;
      end
      return MATCH_NONE;
   endfunction

   function automatic logic [15:0] fold_complement(logic [31:0] s);
      while (s[31:16] != 16'h0000) s = {16'h0000, s[15:0]} + {16'h0000, s[31:16]};
      return ~s[15:0];
   endfunction

   // Build the RST/ACK answer and queue its bytes behind the verdict
   function automatic void queue_reset_reply();
      logic [7:0]   rb [RST_LEN];
      logic [31:0]  ack, sum;
      int           i;
      rsp_item_type item;
      ack = hdr.seq_or_udp_len + 32'd1;
      for (i = 0; i < RST_LEN; i++) rb[i] = 8'h00;
      rb[0]  = IP_VER_IHL;
      rb[3]  = RST_TOTAL_LEN;
      rb[6]  = IP_FLAG_DF;
      rb[8]  = IP_TTL;
      rb[9]  = PROTO_TCP;
      for (i = 0; i < 4; i++) begin
         rb[12+i] = hdr.dest_ip[31-8*i -: 8];
         rb[16+i] = hdr.source_ip[31-8*i -: 8];
         rb[28+i] = ack[31-8*i -: 8];
      end
      rb[20] = DNS_PORT[15:8];
      rb[21] = DNS_PORT[7:0];
      rb[22] = hdr.source_port[15:8];
      rb[23] = hdr.source_port[7:0];
      rb[32] = TCP_OFF_BYTE;
      rb[33] = TCP_FLAGS_RSTACK;
      sum = 32'h0;
      for (i = 0; i < 20; i += 2) sum += {16'h0000, rb[i], rb[i+1]};
      sum = {16'h0000, fold_complement(sum)};
      rb[10] = sum[15:8];
      rb[11] = sum[7:0];
      // pseudo header: addresses, protocol and segment length, then the segment
      sum = 32'(PROTO_TCP) + 32'(RST_TCP_LEN);
      for (i = 12; i < RST_LEN; i += 2) sum += {16'h0000, rb[i], rb[i+1]};
      sum = {16'h0000, fold_complement(sum)};
      rb[36] = sum[15:8];
      rb[37] = sum[7:0];
      for (i = 0; i < RST_LEN; i++) begin
         item.verdict     = VERDICT_TCP_RESET;
         item.reply_byte  = rb[i];
         item.reply_valid = 1'b1;
         item.last_result = (i == RST_LEN - 1);
         rsp_items_due.push_back(item);
      end
   endfunction

   // Advance the packet state by one byte; on the last byte queue the verdict
   function automatic void track_packet_byte(logic [7:0] b, logic last);
      match_kind_type kind;
      rsp_item_type   item;
      if (hdr.byte_count < COUNT_MAX) begin
         capture_header(int'(hdr.byte_count), b);
         hdr.byte_count++;
      end
      if (!last) return;
      kind = classify_packet();
      item.verdict = VERDICT_PASS;
      if (kind != MATCH_NONE) begin
         if (!cfg.bridge_active) item.verdict = VERDICT_BRIDGE_DROP;
         else if (kind == MATCH_UDP) item.verdict = VERDICT_UDP_DIVERT;
         else if (hdr.tcp_flags[TCP_SYN_BIT]) item.verdict = VERDICT_TCP_RESET;
         else item.verdict = VERDICT_TCP_DROP;
      end
      item.reply_byte  = 8'h00;
      item.reply_valid = 1'b0;
      item.last_result = (item.verdict != VERDICT_TCP_RESET);
      rsp_items_due.push_back(item);
      if (item.verdict == VERDICT_TCP_RESET) queue_reset_reply();
      hdr = '0;
   endfunction

   // ---------------------------------------------------------------------
   // Byte driver: present queued bytes, with random idle bursts and hold-offs
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : byte_driver
      logic         keep;
      pkt_byte_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
         idle_left = 0;
      end else begin
         keep = req_ch.valid && !req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            track_packet_byte(req_ch.pkt_byte, req_ch.last_byte);
            bytes_sent++;
         end
         if (!keep) begin
            if (idle_left != 0) begin
               idle_left--;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
               idle_left = $urandom_range(0, 9);
            end else if (bytes_to_send.size() != 0 &&
                         !(bytes_to_send[0].hold && rsp_items_due.size() != 0)) begin
               nxt = bytes_to_send.pop_front();
               req_ch.pkt_byte  <= nxt.value;
               req_ch.last_byte <= nxt.last;
               keep = 1'b1;
            end
         end
         req_ch.valid <= keep;
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: random back-pressure, compare with the oldest item due
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      logic         rdy;
      rsp_item_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (!rsp_ch.reply_valid && rsp_ch.verdict < 3'd5) verdicts_seen[rsp_ch.verdict]++;
            if (rsp_items_due.size() == 0) begin
               $error("unexpected result item: verdict %0d reply_byte %02h reply_valid %0b",
                      rsp_ch.verdict, rsp_ch.reply_byte, rsp_ch.reply_valid);
               error_count++;
            end else begin
               want = rsp_items_due.pop_front();
               if (rsp_ch.verdict !== want.verdict) begin
                  $error("verdict: expected %0d, actual %0d", want.verdict, rsp_ch.verdict);
                  error_count++;
               end
               if (rsp_ch.reply_byte !== want.reply_byte) begin
                  $error("reply_byte: expected %02h, actual %02h",
                         want.reply_byte, rsp_ch.reply_byte);
                  error_count++;
               end
               if (rsp_ch.reply_valid !== want.reply_valid) begin
                  $error("reply_valid: expected %0b, actual %0b",
                         want.reply_valid, rsp_ch.reply_valid);
                  error_count++;
               end
               if (rsp_ch.last_result !== want.last_result) begin
                  $error("last_result: expected %0b, actual %0b",
                         want.last_result, rsp_ch.last_result);
                  error_count++;
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rdy = 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 9);
            rdy = 1'b0;
         end else begin
            rdy = 1'b1;
         end
         rsp_ch.ready <= rdy;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Wait until every byte is taken and every result has come, then settle
   task automatic wait_drained();
      do @(negedge clock);
      while (bytes_to_send.size() != 0 || req_ch.valid || rsp_items_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock);
      while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         CSR_INTERCEPT_ENABLE: cfg.intercept_enable = value[0];
         CSR_DNS_SERVER_IP:    cfg.dns_server_ip    = value;
         CSR_BRIDGE_ACTIVE:    cfg.bridge_active    = value[0];
         default: ;
      endcase
   endtask

   // Single-bit registers get random upper data bits, which must be ignored
   task automatic set_config(input logic en, input logic [31:0] ip, input logic br);
      csr_write(CSR_INTERCEPT_ENABLE, ($urandom() & 32'hFFFF_FFFE) | 32'(en));
      csr_write(CSR_DNS_SERVER_IP, ip);
      csr_write(CSR_BRIDGE_ACTIVE, ($urandom() & 32'hFFFF_FFFE) | 32'(br));
   endtask

   // Lay out a packet of len bytes: filler (random when fill < 0) with the
   // header fields written over it wherever they fall inside the packet
   task automatic send_packet(input logic [3:0] ver, input logic [3:0] ihl,
                              input logic [7:0] proto, input logic [31:0] dip,
                              input logic [15:0] dport, input logic [31:0] word4,
                              input logic [3:0] toff, input logic [7:0] flags,
                              input logic [15:0] tot, input int unsigned len,
                              input int fill, input bit hold);
      logic [7:0]   pb [$];
      int unsigned  h, i;
      pkt_byte_type pe;
      h = 4 * int'(ihl);
      for (i = 0; i < len; i++) pb.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
      pb[0] = {ver, ihl};
      if (len > 2) pb[2] = tot[15:8];
      if (len > 3) pb[3] = tot[7:0];
      if (len > 9) pb[9] = proto;
      for (i = 0; i < 4; i++) begin
         if (16 + i < len) pb[16+i] = dip[31-8*i -: 8];
         if (h + 4 + i < len) pb[h+4+i] = word4[31-8*i -: 8];
      end
      if (h + 2 < len) pb[h+2] = dport[15:8];
      if (h + 3 < len) pb[h+3] = dport[7:0];
      if (h + 12 < len) pb[h+12] = {toff, pb[h+12][3:0]};
      if (h + 13 < len) pb[h+13] = flags;
      for (i = 0; i < len; i++) begin
         pe.value = pb[i];
         pe.last  = (i == len - 1);
         pe.hold  = hold && (i == 0);
         bytes_to_send.push_back(pe);
      end
      packets_queued++;
   endtask

   // Mostly well-formed DNS traffic to the current server, some noise
   task automatic send_random_packet();
      int unsigned sel, h, hb, len, tot, room;
      logic [3:0]  ver, ihl, toff;
      logic [7:0]  proto;
      logic [31:0] dip, w4;
      logic [15:0] dport, ulen;
      bit          hold;
      hold = ($urandom_range(0, 14) == 0);
      if ($urandom_range(0, 9) == 0) begin
         send_packet(4'($urandom), 4'($urandom), 8'($urandom), $urandom, 16'($urandom),
                     $urandom, 4'($urandom), 8'($urandom), 16'($urandom),
                     $urandom_range(1, 48), -1, hold);
      end else begin
         ver = ($urandom_range(0, 19) == 0) ? 4'($urandom) : IP_VERSION;
         sel = $urandom_range(0, 9);
         ihl = (sel < 8) ? 4'd5 : (sel == 8) ? 4'($urandom_range(6, 15))
                                             : 4'($urandom_range(0, 4));
         h   = 4 * int'(ihl);
         hb  = (h < 20) ? 20 : h;
         sel = $urandom_range(0, 19);
         proto = (sel < 9) ? PROTO_UDP : (sel < 18) ? PROTO_TCP : 8'($urandom);
         dip   = ($urandom_range(0, 9) != 0) ? cfg.dns_server_ip : $urandom;
         dport = ($urandom_range(0, 6) != 0) ? DNS_PORT : 16'($urandom_range(50, 56));
         len   = hb + ((proto == PROTO_TCP) ? 20 : 8) + $urandom_range(0, 24);
         sel   = $urandom_range(0, 9);
         tot   = (sel < 8) ? len : (sel == 8) ? len + 1 : $urandom_range(0, len);
         room  = (tot > h) ? tot - h : 0;
         if (proto == PROTO_TCP) begin
            w4   = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom;
            toff = ($urandom_range(0, 6) != 0 && room >= 20)
                   ? 4'($urandom_range(5, (room / 4 > 15) ? 15 : room / 4)) : 4'($urandom);
         end else begin
            sel  = $urandom_range(0, 9);
            ulen = (sel < 3) ? 16'(room)
                 : (sel < 8 && room >= 8) ? 16'($urandom_range(8, room))
                 : 16'($urandom_range(0, room + 4));
            w4   = {ulen, 16'($urandom)};
            toff = 4'($urandom);
         end
         send_packet(ver, ihl, proto, dip, dport, w4, toff, 8'($urandom), 16'(tot),
                     len, -1, hold);
      end
   endtask

   task automatic run_random_phase(input int unsigned count);
      int unsigned i;
      for (i = 0; i < count; i++) send_random_packet();
      wait_drained();
   endtask

   // ---------------------------------------------------------------------
   // Run sequence
   // ---------------------------------------------------------------------
   initial begin : run_sequence
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.pkt_byte  = 8'h00;
      req_ch.last_byte = 1'b0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = CSR_INTERCEPT_ENABLE;
      csr_ch.data      = 32'h0;
      cfg              = '0;
      hdr              = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Registers at reset: interception off, everything passes
      send_packet(4'hF, 4'hF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 4'hF, 8'hFF,
                  16'hFFFF, 1, 255, 1'b0);
      send_packet(IP_VERSION, 4'd5, PROTO_UDP, 32'h0, DNS_PORT, {16'd8, 16'h1234}, 4'h0,
                  8'h00, 16'd28, 28, -1, 1'b0);
      wait_drained();

      // Interception on, all-ones server, bridge up; a write to the spare index
      set_config(1'b1, 32'hFFFF_FFFF, 1'b1);
      csr_write(CSR_UNUSED, $urandom);
      send_packet(IP_VERSION, 4'd5, PROTO_UDP, 32'hFFFF_FFFF, DNS_PORT, {16'd8, 16'hFFFF},
                  4'hF, 8'hFF, 16'd28, 28, 255, 1'b0);
      // SYN with an all-ones sequence: acknowledgment wraps to zero
      send_packet(IP_VERSION, 4'd5, PROTO_TCP, 32'hFFFF_FFFF, DNS_PORT, 32'hFFFF_FFFF,
                  4'd5, 8'h02, 16'd40, 40, 0, 1'b0);
      send_packet(IP_VERSION, 4'd5, PROTO_TCP, 32'hFFFF_FFFF, DNS_PORT, $urandom,
                  4'd5, 8'h10, 16'd40, 40, -1, 1'b0);
      send_packet(IP_VERSION, 4'd5, PROTO_UDP, 32'hFFFF_FFFF, 16'd54, {16'd8, 16'h0},
                  4'h0, 8'h00, 16'd28, 28, -1, 1'b0);
      // Header length below the minimum: port bytes overlap the IP header
      send_packet(IP_VERSION, 4'd4, PROTO_UDP, 32'hFFFF_FFFF, DNS_PORT, {16'd8, 16'h0},
                  4'h0, 8'h00, 16'd28, 28, -1, 1'b0);
      send_packet(4'd6, 4'd5, PROTO_UDP, 32'hFFFF_FFFF, DNS_PORT, {16'd8, 16'h0},
                  4'h0, 8'h00, 16'd28, 28, -1, 1'b0);
      send_packet(IP_VERSION, 4'd5, PROTO_UDP, 32'hFFFF_FFFF, DNS_PORT, {16'd8, 16'h0},
                  4'h0, 8'h00, 16'd29, 28, -1, 1'b0);
      send_packet(IP_VERSION, 4'd5, PROTO_UDP, 32'hFFFF_FFFF, DNS_PORT, {16'd9, 16'h0},
                  4'h0, 8'h00, 16'd28, 28, -1, 1'b0);
      send_packet(IP_VERSION, 4'd5, PROTO_TCP, 32'hFFFF_FFFF, DNS_PORT, $urandom,
                  4'd4, 8'h02, 16'd40, 40, -1, 1'b0);
      send_packet(IP_VERSION, 4'd5, 8'd1, 32'hFFFF_FFFF, DNS_PORT, {16'd8, 16'h0},
                  4'h0, 8'h00, 16'd28, 28, -1, 1'b0);
      send_packet(IP_VERSION, 4'd5, PROTO_UDP, 32'hFFFF_FFFE, DNS_PORT, {16'd8, 16'h0},
                  4'h0, 8'h00, 16'd28, 28, -1, 1'b0);
      // Widest header, held back until the queue of results is empty
      send_packet(IP_VERSION, 4'd15, PROTO_TCP, 32'hFFFF_FFFF, DNS_PORT, $urandom,
                  4'd5, 8'h02, 16'd80, 80, -1, 1'b1);
      wait_drained();

      // Bridge down: matches are dropped
      set_config(1'b1, 32'hFFFF_FFFF, 1'b0);
      send_packet(IP_VERSION, 4'd5, PROTO_UDP, 32'hFFFF_FFFF, DNS_PORT, {16'd8, 16'h0},
                  4'h0, 8'h00, 16'd28, 28, -1, 1'b0);
      send_packet(IP_VERSION, 4'd5, PROTO_TCP, 32'hFFFF_FFFF, DNS_PORT, $urandom,
                  4'd5, 8'h02, 16'd40, 40, -1, 1'b0);
      wait_drained();

      // Random traffic to a random server address
      set_config(1'b1, $urandom, 1'b1);
      run_random_phase(1);

      // Final stretch at full rate on both sides
      calm = 1'b1;
      set_config(1'b1, $urandom, 1'b1);
      run_random_phase(2);

      $display("Covered %0d packets in %0d bytes: header and length corner cases, then random",
               packets_queued, bytes_sent);
      $display("traffic; verdicts pass %0d, udp divert %0d, tcp reset %0d, tcp drop %0d, %s %0d",
               verdicts_seen[0], verdicts_seen[1], verdicts_seen[2], verdicts_seen[3],
               "bridge drop", verdicts_seen[4]);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Guard against a hang
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
